@@ sv/circle_triangle_overlap_test_defines.svh @@
// assertion macros used by the checker file
`ifndef CIRCLE_TRIANGLE_OVERLAP_TEST_DEFINES_SVH
`define CIRCLE_TRIANGLE_OVERLAP_TEST_DEFINES_SVH

// ante must be followed by cons in the same cycle, outside reset
`define CTOT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// expr must never hold outside reset
`define CTOT_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

@@ sv/ctot_pkg.sv @@
package ctot_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int RADIUS_WIDTH = 15;

  // signed edge and offset vectors
  localparam int DIFF_W = COORD_WIDTH + 1;
  // signed product of two vector components
  localparam int PROD_W = 2 * DIFF_W;
  // signed dot product
  localparam int DOT_W  = PROD_W + 1;
  // unsigned magnitude of a positive dot product or a squared length
  localparam int MAG_W  = 2 * COORD_WIDTH + 2;
  localparam int HALF_W = MAG_W / 2;
  localparam int R2_W   = 2 * RADIUS_WIDTH;
  localparam int NEAR_W = (MAG_W > R2_W) ? MAG_W : R2_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int RN_W   = R2_W + MAG_W;
  localparam int CMP_W  = (SQ_W > RN_W) ? SQ_W : RN_W;

  // cycles from a transfer on start to the sampled result strobe
  localparam int CTOT_LATENCY = 8;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [RADIUS_WIDTH-1:0] radius_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [DOT_W-1:0]       dot_t;
  typedef logic        [MAG_W-1:0]       mag_t;
  typedef logic        [HALF_W-1:0]      half_t;
  typedef logic        [R2_W-1:0]        r2_t;
  typedef logic        [CMP_W-1:0]       cmp_t;

  typedef struct packed {
    logic outside;
    logic behind;
    logic beyond;
    logic near_start;
    logic near_end;
  } ctot_flags_t;

  typedef struct packed {
    ctot_flags_t flags;
    logic        along;
  } ctot_edge_res_t;

endpackage

@@ sv/ctot_edge_lane.sv @@
module ctot_edge_lane (
  input  logic                     clk,
  input  ctot_pkg::coord_t         p_x,
  input  ctot_pkg::coord_t         p_y,
  input  ctot_pkg::coord_t         q_x,
  input  ctot_pkg::coord_t         q_y,
  input  ctot_pkg::coord_t         c_x,
  input  ctot_pkg::coord_t         c_y,
  input  ctot_pkg::r2_t            r2,
  output ctot_pkg::ctot_edge_res_t res
);
  import ctot_pkg::*;

  // stage 1: edge and offsets
  diff_t ex_r, ey_r, vx_r, vy_r, wx_r, wy_r;
  // stage 2: products
  prod_t ey_vx_r, ex_vy_r, ex_vx_r, ey_vy_r, ex_wx_r, ey_wy_r;
  prod_t vx2_r, vy2_r, wx2_r, wy2_r, ex2_r, ey2_r;
  // stage 3: dot products
  dot_t  dnv_r, dev_r, dew_r;
  mag_t  v2_r, w2_r, nn_r;
  r2_t   r2_s3_r;
  // stage 4: flags and partial products
  ctot_flags_t flags_s4_r;
  logic [2*HALF_W-1:0]      dd_hh_r, dd_hl_r, dd_ll_r;
  logic [R2_W+HALF_W-1:0]   rn_h_r, rn_l_r;
  // stage 5: full squares
  ctot_flags_t flags_s5_r;
  cmp_t        d2_r, rn_r;
  // stage 6: verdict
  ctot_edge_res_t res_r;

  mag_t  d_mag;
  half_t d_hi, d_lo, nn_hi, nn_lo;

  // d is positive whenever the alongside branch is used
  assign d_mag = dnv_r[MAG_W-1:0];
  assign d_hi  = d_mag[MAG_W-1:HALF_W];
  assign d_lo  = d_mag[HALF_W-1:0];
  assign nn_hi = nn_r[MAG_W-1:HALF_W];
  assign nn_lo = nn_r[HALF_W-1:0];

  always_ff @(posedge clk) begin
    ex_r <= diff_t'(q_x) - diff_t'(p_x);
    ey_r <= diff_t'(q_y) - diff_t'(p_y);
    vx_r <= diff_t'(c_x) - diff_t'(p_x);
    vy_r <= diff_t'(c_y) - diff_t'(p_y);
    wx_r <= diff_t'(c_x) - diff_t'(q_x);
    wy_r <= diff_t'(c_y) - diff_t'(q_y);

    ey_vx_r <= ey_r * vx_r;
    ex_vy_r <= ex_r * vy_r;
    ex_vx_r <= ex_r * vx_r;
    ey_vy_r <= ey_r * vy_r;
    ex_wx_r <= ex_r * wx_r;
    ey_wy_r <= ey_r * wy_r;
    vx2_r   <= vx_r * vx_r;
    vy2_r   <= vy_r * vy_r;
    wx2_r   <= wx_r * wx_r;
    wy2_r   <= wy_r * wy_r;
    ex2_r   <= ex_r * ex_r;
    ey2_r   <= ey_r * ey_r;

    // normal n = (ey, -ex), and dot(n, c - q) equals dot(n, c - p)
    dnv_r   <= dot_t'(ey_vx_r) - dot_t'(ex_vy_r);
    dev_r   <= dot_t'(ex_vx_r) + dot_t'(ey_vy_r);
    dew_r   <= dot_t'(ex_wx_r) + dot_t'(ey_wy_r);
    v2_r    <= mag_t'($unsigned(vx2_r)) + mag_t'($unsigned(vy2_r));
    w2_r    <= mag_t'($unsigned(wx2_r)) + mag_t'($unsigned(wy2_r));
    nn_r    <= mag_t'($unsigned(ex2_r)) + mag_t'($unsigned(ey2_r));
    r2_s3_r <= r2;

    flags_s4_r.outside    <= !dnv_r[DOT_W-1] && (dnv_r != '0);
    flags_s4_r.behind     <= dev_r[DOT_W-1] || (dev_r == '0);
    flags_s4_r.beyond     <= !dew_r[DOT_W-1] && (dew_r != '0);
    flags_s4_r.near_start <= NEAR_W'(v2_r) <= NEAR_W'(r2_s3_r);
    flags_s4_r.near_end   <= NEAR_W'(w2_r) <= NEAR_W'(r2_s3_r);
    dd_hh_r <= d_hi * d_hi;
    dd_hl_r <= d_hi * d_lo;
    dd_ll_r <= d_lo * d_lo;
    rn_h_r  <= r2_s3_r * nn_hi;
    rn_l_r  <= r2_s3_r * nn_lo;

    flags_s5_r <= flags_s4_r;
    d2_r <= (cmp_t'(dd_hh_r) << (2 * HALF_W)) + (cmp_t'(dd_hl_r) << (HALF_W + 1))
          + cmp_t'(dd_ll_r);
    rn_r <= (cmp_t'(rn_h_r) << HALF_W) + cmp_t'(rn_l_r);

    // a zero-length edge never reports outside, so nn is nonzero here
    res_r.flags <= flags_s5_r;
    res_r.along <= d2_r < rn_r;
  end

  assign res = res_r;

endmodule

@@ sv/circle_triangle_overlap_test.sv @@
// channel   | ports                                   | transfer
// ----------+-----------------------------------------+-------------------------------
// input     | start, busy, in_vertex_*, in_centre_*,  | edge with start high, busy low
//           | in_circle_radius                        |
// result    | out_valid, out_overlaps                 | edge ending the out_valid cycle
//
// one query per cycle, sustained; out_valid rises once the transfer has passed the input
// register, six lane stages and output register; lanes do offsets, products, dot
// products, flags with split partials, full squares, compare
// busy is high only during reset and the first cycle after it
// rst_n is synchronous; it clears the valid bits, so queries in flight are dropped
// the receiver cannot stall, so nothing ever holds the pipeline
module circle_triangle_overlap_test (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ctot_pkg::coord_t  in_vertex_a_x,
  input  ctot_pkg::coord_t  in_vertex_a_y,
  input  ctot_pkg::coord_t  in_vertex_b_x,
  input  ctot_pkg::coord_t  in_vertex_b_y,
  input  ctot_pkg::coord_t  in_vertex_c_x,
  input  ctot_pkg::coord_t  in_vertex_c_y,
  input  ctot_pkg::coord_t  in_centre_x,
  input  ctot_pkg::coord_t  in_centre_y,
  input  ctot_pkg::radius_t in_circle_radius,
  output logic              out_valid,
  output logic              out_overlaps
);
  import ctot_pkg::*;

  // valid bits for the input stage and lane stages one to six
  localparam int VALID_W = CTOT_LATENCY - 1;

  logic               busy_r;
  logic [VALID_W-1:0] valid_r;
  logic               out_valid_r;
  logic               out_overlaps_r;
  logic               out_overlaps_nxt;
  logic               accept;

  // input registers
  coord_t  ax_r, ay_r, bx_r, by_r, cx_r, cy_r, ox_r, oy_r;
  radius_t radius_r;
  // radius squared, aligned with lane stage two
  r2_t     r2_s1_r, r2_s2_r;

  ctot_edge_res_t res_ab, res_bc, res_ca;
  logic verdict_ab, verdict_bc, verdict_ca;

  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b1;
      valid_r        <= '0;
      out_valid_r    <= 1'b0;
      out_overlaps_r <= 1'b0;
    end else begin
      busy_r         <= 1'b0;
      valid_r        <= {valid_r[VALID_W-2:0], accept};
      out_valid_r    <= valid_r[VALID_W-1];
      out_overlaps_r <= valid_r[VALID_W-1] && out_overlaps_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    ax_r     <= in_vertex_a_x;
    ay_r     <= in_vertex_a_y;
    bx_r     <= in_vertex_b_x;
    by_r     <= in_vertex_b_y;
    cx_r     <= in_vertex_c_x;
    cy_r     <= in_vertex_c_y;
    ox_r     <= in_centre_x;
    oy_r     <= in_centre_y;
    radius_r <= in_circle_radius;
    r2_s1_r  <= radius_r * radius_r;
    r2_s2_r  <= r2_s1_r;
  end

  // one lane per edge, all in lockstep
  ctot_edge_lane u_lane_ab (
    .clk (clk),
    .p_x (ax_r), .p_y (ay_r),
    .q_x (bx_r), .q_y (by_r),
    .c_x (ox_r), .c_y (oy_r),
    .r2  (r2_s2_r),
    .res (res_ab)
  );

  ctot_edge_lane u_lane_bc (
    .clk (clk),
    .p_x (bx_r), .p_y (by_r),
    .q_x (cx_r), .q_y (cy_r),
    .c_x (ox_r), .c_y (oy_r),
    .r2  (r2_s2_r),
    .res (res_bc)
  );

  ctot_edge_lane u_lane_ca (
    .clk (clk),
    .p_x (cx_r), .p_y (cy_r),
    .q_x (ax_r), .q_y (ay_r),
    .c_x (ox_r), .c_y (oy_r),
    .r2  (r2_s2_r),
    .res (res_ca)
  );

  // per edge: behind the start tests the start vertex, beyond the end tests the
  // end vertex, otherwise the normal distance
  assign verdict_ab = res_ab.flags.behind ? res_ab.flags.near_start :
                      res_ab.flags.beyond ? res_ab.flags.near_end : res_ab.along;
  assign verdict_bc = res_bc.flags.behind ? res_bc.flags.near_start :
                      res_bc.flags.beyond ? res_bc.flags.near_end : res_bc.along;
  assign verdict_ca = res_ca.flags.behind ? res_ca.flags.near_start :
                      res_ca.flags.beyond ? res_ca.flags.near_end : res_ca.along;

  // first edge with the centre outside decides; centre inside all edges overlaps
  always_comb begin
    if (res_ab.flags.outside) begin
      out_overlaps_nxt = verdict_ab;
    end else if (res_bc.flags.outside) begin
      out_overlaps_nxt = verdict_bc;
    end else if (res_ca.flags.outside) begin
      out_overlaps_nxt = verdict_ca;
    end else begin
      out_overlaps_nxt = 1'b1;
    end
  end

  assign busy         = busy_r;
  assign out_valid    = out_valid_r;
  assign out_overlaps = out_overlaps_r;

endmodule

@@ sv/ctot_checker.sv @@
`include "circle_triangle_overlap_test_defines.svh"

module ctot_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_overlaps
);
  import ctot_pkg::*;

  // every result strobe traces back to a transfer a fixed latency earlier
  `CTOT_ASSERT_IMPLY(a_strobe_has_transfer, out_valid, $past(start && !busy, CTOT_LATENCY), "result strobe without a matching transfer")

  // the pipeline never holds off once out of reset
  `CTOT_ASSERT_IMPLY(a_busy_only_after_reset, $past(rst_n), !busy, "busy high outside reset recovery")

  // the flag is quiet between results
  `CTOT_ASSERT_NEVER(a_flag_without_strobe, !out_valid && out_overlaps, "overlap flag without result strobe")

endmodule

bind circle_triangle_overlap_test ctot_checker u_ctot_checker (.*);

@@ sim/tb_circle_triangle_overlap_test.sv @@
module tb_circle_triangle_overlap_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ctot_pkg::*;

  // generous ceiling: ~575 queries, each followed by an idle gap from pick_gap, plus drain
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 100;

  // exact arithmetic for squared dot products, far beyond any overflow here
  typedef logic signed [127:0] exact_t;

  // one circle-versus-triangle query, fields at the port widths
  typedef struct {
    coord_t  ax, ay, bx, by, cx, cy;
    coord_t  ox, oy;
    radius_t r;
  } query_t;

  // a predicted verdict and the query it belongs to, for messages
  typedef struct {
    query_t q;
    bit     overlaps;
    int     id;
  } verdict_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  coord_t  in_vertex_a_x = '0;
  coord_t  in_vertex_a_y = '0;
  coord_t  in_vertex_b_x = '0;
  coord_t  in_vertex_b_y = '0;
  coord_t  in_vertex_c_x = '0;
  coord_t  in_vertex_c_y = '0;
  coord_t  in_centre_x = '0;
  coord_t  in_centre_y = '0;
  radius_t in_circle_radius = '0;
  logic    out_valid;
  logic    out_overlaps;

  // verdicts still owed by the block, oldest first
  verdict_t pending_verdicts[$];
  int       mismatch_count = 0;
  int       sent_count = 0;
  int       cycle_count = 0;
  // busy as seen during the half cycle before each rising edge
  logic     busy_seen = 1'b1;
  // when clear, queries go back to back with no idle cycles
  bit       idle_on = 1'b1;

  circle_triangle_overlap_test dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_vertex_a_x    (in_vertex_a_x),
    .in_vertex_a_y    (in_vertex_a_y),
    .in_vertex_b_x    (in_vertex_b_x),
    .in_vertex_b_y    (in_vertex_b_y),
    .in_vertex_c_x    (in_vertex_c_x),
    .in_vertex_c_y    (in_vertex_c_y),
    .in_centre_x      (in_centre_x),
    .in_centre_y      (in_centre_y),
    .in_circle_radius (in_circle_radius),
    .out_valid        (out_valid),
    .out_overlaps     (out_overlaps)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // one edge p->q with outward normal (e.y, -e.x); returns 1 when this edge
  // decides the answer, which then lands in verdict
  function automatic bit edge_decides(input longint px, input longint py,
                                      input longint qx, input longint qy,
                                      input longint ox, input longint oy,
                                      input exact_t rsq, output bit verdict);
    longint ex, ey, nx, ny, vx, vy, wx, wy, nn, nd;
    ex = qx - px;
    ey = qy - py;
    nx = ey;
    ny = -ex;
    vx = ox - px;
    vy = oy - py;
    wx = ox - qx;
    wy = oy - qy;
    verdict = 1'b0;
    // centre on the inner side or on the edge line: not this edge
    if (nx * vx + ny * vy <= 0)
      return 1'b0;
    // behind the start vertex: inclusive distance to p
    if (ex * vx + ey * vy <= 0) begin
      verdict = exact_t'(vx * vx + vy * vy) <= rsq;
      return 1'b1;
    end
    // beyond the end vertex: inclusive distance to q
    if (ex * wx + ey * wy > 0) begin
      verdict = exact_t'(wx * wx + wy * wy) <= rsq;
      return 1'b1;
    end
    // alongside: strict normal distance, with a zero-length edge never touching
    nn = nx * nx + ny * ny;
    if (nn == 0)
      return 1'b1;
    nd = wx * nx + wy * ny;
    verdict = exact_t'(nd) * exact_t'(nd) < rsq * exact_t'(nn);
    return 1'b1;
  endfunction

  function automatic bit predict_overlap(input query_t q);
    exact_t rsq;
    bit     verdict;
    rsq = exact_t'(longint'(q.r)) * exact_t'(longint'(q.r));
    if (edge_decides(q.ax, q.ay, q.bx, q.by, q.ox, q.oy, rsq, verdict))
      return verdict;
    if (edge_decides(q.bx, q.by, q.cx, q.cy, q.ox, q.oy, rsq, verdict))
      return verdict;
    if (edge_decides(q.cx, q.cy, q.ax, q.ay, q.ox, q.oy, rsq, verdict))
      return verdict;
    // centre inside every edge
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // driving and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // idle length after a transfer: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    if (!idle_on)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    if (roll < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // present one query and hold it until the block takes it; called at a rising
  // edge, returns at a rising edge with start still high when no gap follows
  task automatic send_query(input query_t q);
    verdict_t v;
    int       gap;
    start            <= 1'b1;
    in_vertex_a_x    <= q.ax;
    in_vertex_a_y    <= q.ay;
    in_vertex_b_x    <= q.bx;
    in_vertex_b_y    <= q.by;
    in_vertex_c_x    <= q.cx;
    in_vertex_c_y    <= q.cy;
    in_centre_x      <= q.ox;
    in_centre_y      <= q.oy;
    in_circle_radius <= q.r;
    // transfer happens at the first edge that sees busy low
    do @(posedge clk); while (busy_seen !== 1'b0);
    v.q        = q;
    v.overlaps = predict_overlap(q);
    v.id       = sent_count;
    pending_verdicts.push_back(v);
    sent_count++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // results are sampled mid-cycle, so each strobe is seen exactly once
  always @(negedge clk) begin
    verdict_t v;
    busy_seen <= busy;
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        report_mismatch("out_valid is unknown");
      end else if (out_valid) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("result %0b with no query outstanding", out_overlaps));
        end else begin
          v = pending_verdicts.pop_front();
          if (out_overlaps !== v.overlaps)
            report_mismatch($sformatf(
              "query %0d a(%0d,%0d) b(%0d,%0d) c(%0d,%0d) o(%0d,%0d) r %0d: got %0b want %0b",
              v.id, v.q.ax, v.q.ay, v.q.bx, v.q.by, v.q.cx, v.q.cy, v.q.ox, v.q.oy,
              v.q.r, out_overlaps, v.overlaps));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // query builders
  // ---------------------------------------------------------------------------

  function automatic query_t make_query(input int ax, input int ay, input int bx,
                                        input int by, input int cx, input int cy,
                                        input int ox, input int oy, input int r);
    query_t q;
    q.ax = coord_t'(ax);
    q.ay = coord_t'(ay);
    q.bx = coord_t'(bx);
    q.by = coord_t'(by);
    q.cx = coord_t'(cx);
    q.cy = coord_t'(cy);
    q.ox = coord_t'(ox);
    q.oy = coord_t'(oy);
    q.r  = radius_t'(r);
    return q;
  endfunction

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // small triangle somewhere in the plane with the circle close by
  function automatic query_t make_local_query();
    int bx0, by0;
    bx0 = jitter(30000);
    by0 = jitter(30000);
    return make_query(bx0 + jitter(512), by0 + jitter(512), bx0 + jitter(512),
                      by0 + jitter(512), bx0 + jitter(512), by0 + jitter(512),
                      bx0 + jitter(768), by0 + jitter(768), $urandom_range(0, 600));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked cases: each branch, its boundary, and the field extremes
  task automatic test_directed_corners();
    // counter-clockwise right triangle, centre inside
    send_query(make_query(0, 0, 160, 0, 0, 160, 16, 16, 0));
    // alongside edge ab: exact tangency is a miss, one step more is a hit
    send_query(make_query(0, 0, 160, 0, 0, 160, 80, -32, 32));
    send_query(make_query(0, 0, 160, 0, 0, 160, 80, -32, 33));
    // behind the start vertex, inclusive distance
    send_query(make_query(0, 0, 160, 0, 0, 160, -30, -40, 50));
    send_query(make_query(0, 0, 160, 0, 0, 160, -30, -40, 49));
    // beyond the end vertex, inclusive distance
    send_query(make_query(0, 0, 160, 0, 0, 160, 190, -40, 50));
    send_query(make_query(0, 0, 160, 0, 0, 160, 190, -40, 49));
    // clockwise winding: inside point reads as outside edge ab
    send_query(make_query(0, 0, 0, 160, 160, 0, 16, 16, 16));
    send_query(make_query(0, 0, 0, 160, 160, 0, 16, 16, 17));
    // zero-length edge ab is skipped, edge bc decides
    send_query(make_query(0, 0, 0, 0, 160, 0, 80, -32, 40));
    send_query(make_query(0, 0, 0, 0, 160, 0, 80, -32, 31));
    // all three vertices equal: no edge has the centre outside
    send_query(make_query(100, 100, 100, 100, 100, 100, -5000, 7000, 0));
    // collinear vertices
    send_query(make_query(0, 0, 100, 100, 200, 200, 150, 40, 30));
    // centre on a vertex with zero radius
    send_query(make_query(0, 0, 160, 0, 0, 160, 160, 0, 0));
    // field extremes
    send_query(make_query(-32768, -32768, 32767, -32768, -32768, 32767,
                          32767, 32767, 32767));
    send_query(make_query(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0, 0));
    send_query(make_query(-32768, -32768, 32767, -32768, -32768, 32767,
                          32767, 32767, 0));
    send_query(make_query(32767, 32767, -32768, 32767, 32767, -32768,
                          -32768, -32768, 32767));
    send_query(make_query(-32768, 32767, -32768, -32768, 32767, 0,
                          32767, 32767, 16384));
    send_query(make_query(0, 0, 0, 0, 0, 0, -32768, -32768, 32767));
    send_query(make_query(-1, -1, -1, -1, -1, -1, -1, -1, 0));
  endtask

  // small triangles with nearby circles, with idling switched in and out
  task automatic test_local_triangles();
    for (int i = 0; i < 200; i++) begin
      if (i % 25 == 0)
        idle_on = ($urandom_range(0, 3) != 0);
      send_query(make_local_query());
    end
    idle_on = 1'b1;
  endtask

  // every field uniform over its whole range
  task automatic test_full_range();
    query_t q;
    for (int i = 0; i < 120; i++) begin
      q.ax = coord_t'($urandom);
      q.ay = coord_t'($urandom);
      q.bx = coord_t'($urandom);
      q.by = coord_t'($urandom);
      q.cx = coord_t'($urandom);
      q.cy = coord_t'($urandom);
      q.ox = coord_t'($urandom);
      q.oy = coord_t'($urandom);
      q.r  = radius_t'($urandom);
      send_query(q);
    end
  endtask

  // repeated vertices, collinear points and two near-coincident vertices
  task automatic test_degenerate_triangles();
    query_t q;
    for (int i = 0; i < 80; i++) begin
      q = make_local_query();
      case ($urandom_range(0, 5))
        0: begin
          q.bx = q.ax;
          q.by = q.ay;
        end
        1: begin
          q.cx = q.bx;
          q.cy = q.by;
        end
        2: begin
          q.ax = q.cx;
          q.ay = q.cy;
        end
        3: begin
          q.bx = q.ax;
          q.by = q.ay;
          q.cx = q.ax;
          q.cy = q.ay;
        end
        4: begin
          q.cx = coord_t'(2 * int'(q.bx) - int'(q.ax));
          q.cy = coord_t'(2 * int'(q.by) - int'(q.ay));
        end
        default: begin
          q.bx = q.cx;
          q.by = q.cy;
          q = make_query(q.ax, q.ay, q.cx, q.cy, q.bx + jitter(300), q.by + jitter(300),
                         q.ox, q.oy, q.r);
        end
      endcase
      send_query(q);
    end
  endtask

  // circles that just reach a vertex or an edge, and one step either side
  task automatic test_boundary_distances();
    int x0, y0, len, hgt, clearance, k, sx, sy, vx, vy;
    query_t q;
    for (int i = 0; i < 100; i++) begin
      x0   = jitter(30000);
      y0   = jitter(30000);
      len  = $urandom_range(1, 600);
      hgt  = $urandom_range(1, 600);
      sx   = $urandom_range(0, 1) ? 1 : -1;
      sy   = $urandom_range(0, 1) ? 1 : -1;
      if ($urandom_range(0, 1)) begin
        // flat bottom edge, circle below it at a known distance
        clearance = $urandom_range(0, 400);
        q = make_query(x0, y0, x0 + len, y0, x0 + jitter(600), y0 + hgt,
                       x0 + $urandom_range(0, len), y0 - clearance,
                       clearance + jitter(1));
        if ($urandom_range(0, 1))
          q = make_query(q.ay, q.ax, q.cy, q.cx, q.by, q.bx, q.oy, q.ox, q.r);
      end else begin
        // 3-4-5 offset from one vertex
        k  = $urandom_range(1, 100);
        q  = make_query(x0, y0, x0 + len, y0 + jitter(200), x0 + jitter(300), y0 + hgt,
                        0, 0, 5 * k + jitter(1));
        case ($urandom_range(0, 2))
          0: begin
            vx = q.ax;
            vy = q.ay;
          end
          1: begin
            vx = q.bx;
            vy = q.by;
          end
          default: begin
            vx = q.cx;
            vy = q.cy;
          end
        endcase
        if ($urandom_range(0, 1)) begin
          q.ox = coord_t'(vx + sx * 3 * k);
          q.oy = coord_t'(vy + sy * 4 * k);
        end else begin
          q.ox = coord_t'(vx + sx * 4 * k);
          q.oy = coord_t'(vy + sy * 3 * k);
        end
      end
      send_query(q);
    end
  endtask

  // one query per cycle with no idling at all
  task automatic test_back_to_back();
    idle_on = 1'b0;
    for (int i = 0; i < 50; i++)
      send_query(make_local_query());
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    // synchronous reset held from the start, released at a rising edge
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_local_triangles();
    test_full_range();
    test_degenerate_triangles();
    test_boundary_distances();
    test_back_to_back();

    // stop offering queries, then drain the pipeline
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (CTOT_LATENCY + 4) @(posedge clk);

    if (mismatch_count == 0)
      $display("tb_circle_triangle_overlap_test: done, clean");
    else
      $display("tb_circle_triangle_overlap_test: done, errors");
    $finish;
  end

  // watchdog against a hung handshake or lost results
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_circle_triangle_overlap_test: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/ctot_pkg.sv
sv/ctot_edge_lane.sv
sv/circle_triangle_overlap_test.sv
sv/ctot_checker.sv
sim/tb_circle_triangle_overlap_test.sv
